// File: hdl/assert_macros.svh
// assertion macros shared by the coverage tracker modules
// no dependencies; included by the files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every clock edge outside reset
`define PCT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("pct assertion failed");

// expression must never be true outside reset
`define PCT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("pct forbidden condition seen");

`endif

// File: hdl/pct_pkg.sv
// types and fixed constants of the pairwise coverage tracker
// no dependencies; imported by the top, sequencer and evaluation modules
package pct_pkg;

  // fixed widths of the port fields
  localparam int NV_W    = 7;
  localparam int NEW_W   = 11;
  localparam int TOT_W   = 13;
  localparam int CNT_W   = 7;
  // one map word holds the four value combinations of one variable pair
  localparam int COMBO_W = 4;

  typedef enum logic [1:0] {
    OP_GAIN   = 2'd0,
    OP_COMMIT = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_SCAN,
    S_READ,
    S_WAIT
  } state_e;

  typedef enum logic [1:0] {
    K_SCAN,
    K_READ,
    K_ZERO,
    K_CLEAR
  } kind_e;

  // one map access handed from the sequencer to the evaluation stage
  typedef struct packed {
    logic  valid;
    kind_e kind;
    logic  first;
    logic  last;
    logic  commit;
    logic  vi;
    logic  vj;
    logic  v_is_j;
  } probe_t;

endpackage

// File: hdl/pairwise_coverage_tracker.sv
// Gain query and commit: one map word a cycle, then the strobe after the registered probe
// and the done register; the next item is accepted only once the strobe has been seen.
// A count read walks the partners of the selected variable, a read of a variable at or above N
// gets zero counts at once, and a clear sweeps every word of the map.
// Results are strobed for one cycle and the receiver cannot stall; the single map port sets
// the rate. Reset, and a num_vars write while idle, start a clearing pass with busy high.
`include "assert_macros.svh"

module pairwise_coverage_tracker #(
  parameter int MAX_VARS = 64,
  localparam int PAIRS  = MAX_VARS * (MAX_VARS - 1) / 2,
  localparam int ADDR_W = (PAIRS > 1) ? $clog2(PAIRS) : 1,
  localparam int VAR_W  = $clog2(MAX_VARS)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  operation_i,
  input  logic [MAX_VARS-1:0]         assignment_i,
  input  logic [VAR_W-1:0]            var_index_i,
  input  logic                        cfg_we_i,
  input  logic [pct_pkg::NV_W-1:0]    cfg_wdata_i,
  output logic                        done_o,
  output logic [pct_pkg::NEW_W-1:0]   new_pairs_o,
  output logic [pct_pkg::TOT_W-1:0]   total_covered_o,
  output logic [pct_pkg::CNT_W-1:0]   pos_uncovered_o,
  output logic [pct_pkg::CNT_W-1:0]   neg_uncovered_o
);

  import pct_pkg::*;

  probe_t               probe;
  logic [ADDR_W-1:0]    seq_addr;
  logic                 clr_we;
  logic                 ev_we;
  logic [ADDR_W-1:0]    ev_waddr;
  logic [COMBO_W-1:0]   ev_wdata;
  logic [COMBO_W-1:0]   rdata;
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [COMBO_W-1:0]   ram_wdata;

  // control and address walk
  pct_seq #(
    .MAX_VARS (MAX_VARS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .op_i        (operation_i),
    .asg_i       (assignment_i),
    .var_i       (var_index_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .done_i      (done_o),
    .busy_o      (busy),
    .addr_o      (seq_addr),
    .clr_we_o    (clr_we),
    .probe_o     (probe)
  );

  // write port shared between the clearing sweep and the commit write back;
  // each pass visits every map word once, so a read never meets a pending write
  assign ram_we    = clr_we | ev_we;
  assign ram_waddr = clr_we ? seq_addr : ev_waddr;
  assign ram_wdata = clr_we ? '0 : ev_wdata;

  // coverage map: one word of four value-combination bits per variable pair
  pct_ram #(
    .WIDTH (COMBO_W),
    .DEPTH (PAIRS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (seq_addr),
    .rdata_o (rdata)
  );

  // evaluation and result word
  pct_eval #(
    .MAX_VARS (MAX_VARS)
  ) u_eval (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_clr_i (cfg_we_i),
    .probe_i   (probe),
    .addr_i    (seq_addr),
    .rdata_i   (rdata),
    .we_o      (ev_we),
    .waddr_o   (ev_waddr),
    .wdata_o   (ev_wdata),
    .done_o    (done_o),
    .new_o     (new_pairs_o),
    .tot_o     (total_covered_o),
    .pos_o     (pos_uncovered_o),
    .neg_o     (neg_uncovered_o)
  );

  `PCT_ASSERT(a_done_single, clk_i, rst_ni, done_o |=> !done_o)
  `PCT_ASSERT(a_done_while_busy, clk_i, rst_ni, done_o |-> busy)
  `PCT_NEVER(a_no_write_clash, clk_i, rst_ni, clr_we && ev_we)

endmodule

// File: hdl/pct_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module pct_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 2016,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/pct_seq.sv
// sequencer: control fsm, pair and partner address walk, clearing sweep
// depends on pct_pkg and assert_macros.svh
`include "assert_macros.svh"

module pct_seq #(
  parameter int MAX_VARS = 64,
  localparam int PAIRS  = MAX_VARS * (MAX_VARS - 1) / 2,
  localparam int ADDR_W = (PAIRS > 1) ? $clog2(PAIRS) : 1,
  localparam int VAR_W  = $clog2(MAX_VARS),
  localparam int NVAR_W = $clog2(MAX_VARS + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [1:0]             op_i,
  input  logic [MAX_VARS-1:0]    asg_i,
  input  logic [VAR_W-1:0]       var_i,
  input  logic                   cfg_we_i,
  input  logic [pct_pkg::NV_W-1:0] cfg_wdata_i,
  input  logic                   done_i,
  output logic                   busy_o,
  output logic [ADDR_W-1:0]      addr_o,
  output logic                   clr_we_o,
  output pct_pkg::probe_t        probe_o
);

  import pct_pkg::*;

  localparam int K_W = VAR_W + 1;

  state_e                state_q, state_d;
  op_e                   op_q, op_d;
  logic [MAX_VARS-1:0]   asg_q, asg_d;
  logic [VAR_W-1:0]      var_q, var_d;
  logic [NVAR_W-1:0]     n_q, n_d;
  logic [ADDR_W-1:0]     addr_q, addr_d;
  logic [VAR_W-1:0]      i_q, i_d;
  logic [VAR_W-1:0]      j_q, j_d;
  logic                  first_q, first_d;
  logic                  clr_op_q, clr_op_d;

  logic [NVAR_W-1:0]     n_m1, n_m2, n_clamp;
  logic                  scan_row_end, scan_last;
  logic [K_W-1:0]        kp1, kn;
  logic                  k_adj, k_below, rd_last;
  logic                  sel_in_range;
  logic [ADDR_W-1:0]     rd_step;

  // clamp the written variable count into 2..MAX_VARS
  always_comb begin
    if (cfg_wdata_i < NV_W'(2)) begin
      n_clamp = NVAR_W'(2);
    end else if (cfg_wdata_i > NV_W'(MAX_VARS)) begin
      n_clamp = NVAR_W'(MAX_VARS);
    end else begin
      n_clamp = NVAR_W'(cfg_wdata_i);
    end
  end

  // pair walk: i over rows, j over partners above i
  assign n_m1         = n_q - NVAR_W'(1);
  assign n_m2         = n_q - NVAR_W'(2);
  assign scan_row_end = (NVAR_W'(j_q) == n_m1);
  assign scan_last    = scan_row_end && (NVAR_W'(i_q) == n_m2);

  // partner walk for a count read: i_q is the partner k, skipping var_q
  assign kp1     = K_W'(i_q) + K_W'(1);
  assign k_adj   = (kp1 == K_W'(var_q));
  assign kn      = k_adj ? kp1 + K_W'(1) : kp1;
  assign k_below = (i_q < var_q);
  assign rd_last = (kn >= K_W'(n_q));
  assign rd_step = k_below ?
                   ADDR_W'(n_q) - ADDR_W'(i_q) - ADDR_W'(2) + ADDR_W'(k_adj) :
                   ADDR_W'(1);
  assign sel_in_range = (NVAR_W'(var_i) < n_q);

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      n_q      <= NVAR_W'(MAX_VARS);
      addr_q   <= '0;
      first_q  <= 1'b0;
      clr_op_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      n_q      <= n_d;
      addr_q   <= addr_d;
      first_q  <= first_d;
      clr_op_q <= clr_op_d;
    end
  end

  // latched item payload and walk indices
  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    asg_q <= asg_d;
    var_q <= var_d;
    i_q   <= i_d;
    j_q   <= j_d;
  end

  // next state and probe issue
  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    asg_d    = asg_q;
    var_d    = var_q;
    n_d      = n_q;
    addr_d   = addr_q;
    i_d      = i_q;
    j_d      = j_q;
    first_d  = first_q;
    clr_op_d = clr_op_q;
    clr_we_o = 1'b0;
    probe_o  = '0;
    busy_o   = (state_q != S_IDLE);

    unique case (state_q)
      S_IDLE: begin
        if (cfg_we_i) begin
          n_d      = n_clamp;
          addr_d   = '0;
          clr_op_d = 1'b0;
          state_d  = S_CLEAR;
        end else if (start_i) begin
          op_d    = op_e'(op_i);
          asg_d   = asg_i;
          var_d   = var_i;
          first_d = 1'b1;
          unique case (op_e'(op_i))
            OP_GAIN, OP_COMMIT: begin
              addr_d  = '0;
              i_d     = '0;
              j_d     = VAR_W'(1);
              state_d = S_SCAN;
            end
            OP_READ: begin
              if (!sel_in_range) begin
                // variable not in use: answer at once with zero counts
                probe_o.valid = 1'b1;
                probe_o.kind  = K_ZERO;
                probe_o.first = 1'b1;
                probe_o.last  = 1'b1;
                state_d       = S_WAIT;
              end else if (var_i == '0) begin
                i_d     = VAR_W'(1);
                addr_d  = '0;
                state_d = S_READ;
              end else begin
                i_d     = '0;
                addr_d  = ADDR_W'(var_i) - ADDR_W'(1);
                state_d = S_READ;
              end
            end
            OP_CLEAR: begin
              addr_d   = '0;
              clr_op_d = 1'b1;
              state_d  = S_CLEAR;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end

      S_CLEAR: begin
        // one map word zeroed per cycle
        clr_we_o = 1'b1;
        if (addr_q == ADDR_W'(PAIRS - 1)) begin
          if (clr_op_q) begin
            probe_o.valid = 1'b1;
            probe_o.kind  = K_CLEAR;
            probe_o.first = 1'b1;
            probe_o.last  = 1'b1;
            state_d       = S_WAIT;
          end else begin
            state_d = S_IDLE;
          end
        end else begin
          addr_d = addr_q + ADDR_W'(1);
        end
      end

      S_SCAN: begin
        probe_o.valid  = 1'b1;
        probe_o.kind   = K_SCAN;
        probe_o.first  = first_q;
        probe_o.last   = scan_last;
        probe_o.commit = (op_q == OP_COMMIT);
        probe_o.vi     = asg_q[i_q];
        probe_o.vj     = asg_q[j_q];
        first_d        = 1'b0;
        addr_d         = addr_q + ADDR_W'(1);
        if (scan_last) begin
          state_d = S_WAIT;
        end else if (scan_row_end) begin
          i_d = i_q + VAR_W'(1);
          j_d = i_q + VAR_W'(2);
        end else begin
          j_d = j_q + VAR_W'(1);
        end
      end

      S_READ: begin
        probe_o.valid  = 1'b1;
        probe_o.kind   = K_READ;
        probe_o.first  = first_q;
        probe_o.last   = rd_last;
        probe_o.v_is_j = k_below;
        first_d        = 1'b0;
        addr_d         = addr_q + rd_step;
        i_d            = kn[VAR_W-1:0];
        if (rd_last) begin
          state_d = S_WAIT;
        end
      end

      S_WAIT: begin
        if (done_i) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  assign addr_o = addr_q;

  `PCT_ASSERT(a_accept_leaves_idle, clk_i, rst_ni,
    (start_i && !busy_o) |=> (state_q != S_IDLE))
  `PCT_NEVER(a_addr_in_range, clk_i, rst_ni,
    (probe_o.valid && (probe_o.kind == K_SCAN || probe_o.kind == K_READ)) &&
    (addr_q > ADDR_W'(PAIRS - 1)))

endmodule

// File: hdl/pct_eval.sv
// evaluation stage: checks read map words, writes back covered bits,
// accumulates counts and holds the result word; depends on pct_pkg
module pct_eval #(
  parameter int MAX_VARS = 64,
  localparam int PAIRS  = MAX_VARS * (MAX_VARS - 1) / 2,
  localparam int ADDR_W = (PAIRS > 1) ? $clog2(PAIRS) : 1,
  localparam int FND_W  = $clog2(PAIRS + 1),
  localparam int COV_W  = $clog2(4 * PAIRS + 1),
  localparam int CNT_IW = $clog2(2 * (MAX_VARS - 1) + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_clr_i,
  input  pct_pkg::probe_t               probe_i,
  input  logic [ADDR_W-1:0]             addr_i,
  input  logic [pct_pkg::COMBO_W-1:0]   rdata_i,
  output logic                          we_o,
  output logic [ADDR_W-1:0]             waddr_o,
  output logic [pct_pkg::COMBO_W-1:0]   wdata_o,
  output logic                          done_o,
  output logic [pct_pkg::NEW_W-1:0]     new_o,
  output logic [pct_pkg::TOT_W-1:0]     tot_o,
  output logic [pct_pkg::CNT_W-1:0]     pos_o,
  output logic [pct_pkg::CNT_W-1:0]     neg_o
);

  import pct_pkg::*;

  probe_t              probe_q;
  logic [ADDR_W-1:0]   addr_q;
  logic [FND_W-1:0]    found_q, found_d;
  logic [CNT_IW-1:0]   pos_q, pos_d, neg_q, neg_d;
  logic [COV_W-1:0]    cov_q, cov_d;
  logic                done_q;
  logic [NEW_W-1:0]    new_q;
  logic [TOT_W-1:0]    tot_q;
  logic [CNT_W-1:0]    rpos_q, rneg_q;

  logic [1:0]          combo;
  logic                fresh, is_scan, is_read, mark;
  logic [1:0]          pos_bits, neg_bits;
  logic [CNT_IW-1:0]   pos_inc, neg_inc;

  // probe travels alongside the ram read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_q <= '0;
    end else begin
      probe_q <= probe_i;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_i;
  end

  // pair lookup and write back
  assign combo   = {probe_q.vi, probe_q.vj};
  assign fresh   = !rdata_i[combo];
  assign is_scan = probe_q.valid && (probe_q.kind == K_SCAN);
  assign is_read = probe_q.valid && (probe_q.kind == K_READ);
  assign mark    = is_scan && probe_q.commit && fresh;
  assign we_o    = mark;
  assign waddr_o = addr_q;
  assign wdata_o = rdata_i | (COMBO_W'(1) << combo);

  // uncovered combinations of the selected variable, by polarity
  assign pos_bits = probe_q.v_is_j ? {rdata_i[3], rdata_i[1]} : {rdata_i[3], rdata_i[2]};
  assign neg_bits = probe_q.v_is_j ? {rdata_i[2], rdata_i[0]} : {rdata_i[1], rdata_i[0]};
  assign pos_inc  = CNT_IW'(!pos_bits[0]) + CNT_IW'(!pos_bits[1]);
  assign neg_inc  = CNT_IW'(!neg_bits[0]) + CNT_IW'(!neg_bits[1]);

  // accumulators; item sums restart on an item's first probe, the total is zeroed by clears
  always_comb begin
    found_d = (probe_q.first ? '0 : found_q) + FND_W'(is_scan && fresh);
    pos_d   = (probe_q.first ? '0 : pos_q) + (is_read ? pos_inc : '0);
    neg_d   = (probe_q.first ? '0 : neg_q) + (is_read ? neg_inc : '0);
    priority if (cfg_clr_i) begin
      cov_d = '0;
    end else if (probe_q.valid && probe_q.kind == K_CLEAR) begin
      cov_d = '0;
    end else if (mark) begin
      cov_d = cov_q + COV_W'(1);
    end else begin
      cov_d = cov_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cov_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cov_q  <= cov_d;
      done_q <= probe_q.valid && probe_q.last;
    end
  end

  // running sums and result word
  always_ff @(posedge clk_i) begin
    if (probe_q.valid) begin
      found_q <= found_d;
      pos_q   <= pos_d;
      neg_q   <= neg_d;
    end
    if (probe_q.valid && probe_q.last) begin
      new_q  <= NEW_W'(found_d);
      tot_q  <= TOT_W'(cov_d);
      rpos_q <= CNT_W'(pos_d);
      rneg_q <= CNT_W'(neg_d);
    end
  end

  assign done_o = done_q;
  assign new_o  = new_q;
  assign tot_o  = tot_q;
  assign pos_o  = rpos_q;
  assign neg_o  = rneg_q;

endmodule
